// ===== sv/slpg_pkg.sv =====
// Shared types, constants and table functions for the synthetic lidar point generator.
`default_nettype none
package slpg_pkg;

  // Default configuration.
  localparam int RING_COUNT_DEF      = 16;
  localparam int STEPS_PER_REV_DEF   = 30000;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Quarter turn in Q2.30 radians.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  // Elevation sine and cosine in Q1.15 for the sixteen lasers.
  localparam logic signed [15:0] ELEV_SIN [16] = '{
    -16'sd8481, 16'sd572, -16'sd7371, 16'sd1715, -16'sd6252, 16'sd2856, -16'sd5126, 16'sd3993,
    -16'sd3993, 16'sd5126, -16'sd2856, 16'sd6252, -16'sd1715, 16'sd7371, -16'sd572, 16'sd8481
  };
  localparam logic signed [15:0] ELEV_COS [16] = '{
    16'sd31651, 16'sd32763, 16'sd31928, 16'sd32723, 16'sd32166, 16'sd32643, 16'sd32365,
    16'sd32524, 16'sd32524, 16'sd32365, 16'sd32643, 16'sd32166, 16'sd32723, 16'sd31928,
    16'sd32763, 16'sd31651
  };

  // Multiplier operand selection codes.
  typedef enum logic [1:0] {
    MUL_RH = 2'd0,
    MUL_PZ = 2'd1,
    MUL_PX = 2'd2,
    MUL_PY = 2'd3
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     look;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // Quarter-wave sine entry in Q1.15, evaluated at elaboration to fill the table.
  function automatic logic [16:0] quarter_sine(input int q, input int bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (longint'(q) * HALF_PI_Q30) >> (bits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[16:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/synthetic_lidar_point_generator_top.sv =====
// Top level of the synthetic lidar point generator.
// Each input transfer is one scan tick carrying a nanosecond timestamp and a
// sink-full flag; each tick yields exactly one output point transfer.
// Input and output channels use valid/ready handshakes.
// A point passes through a capture step, a table lookup step, four steps on the
// single shared multiplier and a step that loads the output register; the
// sequencer takes no new tick until the current point has been loaded into
// the output register.
// The output register holds a finished point while the receiver stalls; the
// next tick is accepted and computed meanwhile and waits at its final step
// until the output register frees up.
// Reset clears the ring counter, azimuth phase and both point counters and
// empties the output register. The counters wrap modulo 2^32.
`default_nettype none
module synthetic_lidar_point_generator_top #(
  parameter int RING_COUNT      = slpg_pkg::RING_COUNT_DEF,
  parameter int STEPS_PER_REV   = slpg_pkg::STEPS_PER_REV_DEF,
  parameter int SINE_TABLE_BITS = slpg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire [63:0]         tick_time_ns_i,
  input  wire                sink_full_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0]        brightness_o,
  output logic [3:0]         laser_ring_o,
  output logic [63:0]        stamp_ns_o,
  output logic               accepted_o,
  output logic [31:0]        dropped_total_o,
  output logic [31:0]        published_total_o
);

  slpg_pkg::cmd_t    cmd;
  slpg_pkg::status_t status;

  slpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slpg_dp #(
    .RING_COUNT      (RING_COUNT),
    .STEPS_PER_REV   (STEPS_PER_REV),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .tick_time_ns_i    (tick_time_ns_i),
    .sink_full_i       (sink_full_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pos_x_o           (pos_x_o),
    .pos_y_o           (pos_y_o),
    .pos_z_o           (pos_z_o),
    .brightness_o      (brightness_o),
    .laser_ring_o      (laser_ring_o),
    .stamp_ns_o        (stamp_ns_o),
    .accepted_o        (accepted_o),
    .dropped_total_o   (dropped_total_o),
    .published_total_o (published_total_o)
  );

  // An accepted tick keeps the sequencer busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while sequencer busy");

  // A stalled output is never overwritten by a finished point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !cmd.out_load)
    else $error("output register overwritten during stall");

  // Intensity always lies within its Q8.8 range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (brightness_o >= 16'd16384) && (brightness_o <= 16'd49152))
    else $error("brightness out of range");

endmodule
`default_nettype wire

// ===== sv/slpg_ctrl.sv =====
// Controller state machine that sequences one point through the datapath.
`default_nettype none
module slpg_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  slpg_pkg::status_t  status_i,
  output slpg_pkg::cmd_t     cmd_o
);

  slpg_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slpg_pkg::ST_IDLE: if (in_valid_i) state_d = slpg_pkg::ST_LOOK;
      slpg_pkg::ST_LOOK: state_d = slpg_pkg::ST_MUL0;
      slpg_pkg::ST_MUL0: state_d = slpg_pkg::ST_MUL1;
      slpg_pkg::ST_MUL1: state_d = slpg_pkg::ST_MUL2;
      slpg_pkg::ST_MUL2: state_d = slpg_pkg::ST_MUL3;
      slpg_pkg::ST_MUL3: state_d = slpg_pkg::ST_FIN;
      slpg_pkg::ST_FIN:  if (status_i.out_free) state_d = slpg_pkg::ST_IDLE;
      default:           state_d = slpg_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = slpg_pkg::MUL_RH;
    in_ready_o    = 1'b0;
    unique case (state_q)
      slpg_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      slpg_pkg::ST_LOOK: cmd_o.look = 1'b1;
      slpg_pkg::ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = slpg_pkg::MUL_RH;
      end
      slpg_pkg::ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = slpg_pkg::MUL_PZ;
      end
      slpg_pkg::ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = slpg_pkg::MUL_PX;
      end
      slpg_pkg::ST_MUL3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = slpg_pkg::MUL_PY;
      end
      slpg_pkg::ST_FIN: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/slpg_dp.sv =====
// Datapath: phase accumulators, sine table, shared multiplier and output register.
`default_nettype none
module slpg_dp #(
  parameter int RING_COUNT      = slpg_pkg::RING_COUNT_DEF,
  parameter int STEPS_PER_REV   = slpg_pkg::STEPS_PER_REV_DEF,
  parameter int SINE_TABLE_BITS = slpg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  slpg_pkg::cmd_t       cmd_i,
  output slpg_pkg::status_t    status_o,
  input  wire [63:0]           tick_time_ns_i,
  input  wire                  sink_full_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic signed [15:0]   pos_x_o,
  output logic signed [15:0]   pos_y_o,
  output logic signed [15:0]   pos_z_o,
  output logic [15:0]          brightness_o,
  output logic [3:0]           laser_ring_o,
  output logic [63:0]          stamp_ns_o,
  output logic                 accepted_o,
  output logic [31:0]          dropped_total_o,
  output logic [31:0]          published_total_o
);

  localparam int B    = SINE_TABLE_BITS;
  localparam int QN   = 1 << (B - 2);
  localparam int RW   = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
  localparam int REMW = $clog2(4 * STEPS_PER_REV);
  localparam int TWO_S = 2 * STEPS_PER_REV;
  localparam int MULT [3] = '{1, 3, 7};

  // Quarter-wave table, filled at elaboration.
  logic [16:0] qtab [QN + 1];
  for (genvar g = 0; g <= QN; g++) begin : g_tab
    assign qtab[g] = slpg_pkg::quarter_sine(g, B);
  end

  // Signed sine at a table index, mirrored by quadrant.
  function automatic logic signed [17:0] sine_at(input logic [B-1:0] idx,
                                                 input logic [16:0] tab [QN + 1]);
    logic [1:0]   quad;
    logic [B-2:0] q;
    logic [B-2:0] m;
    logic [17:0]  v;
    quad = idx[B-1:B-2];
    q    = {1'b0, idx[B-3:0]};
    m    = (B-1)'(QN) - q;
    case (quad)
      2'd0:    v = {1'b0, tab[q]};
      2'd1:    v = {1'b0, tab[m]};
      2'd2:    v = -{1'b0, tab[q]};
      default: v = -{1'b0, tab[m]};
    endcase
    return $signed(v);
  endfunction

  // Phase state: table index and rounding remainder for each harmonic.
  logic [B-1:0]    idx_q [3];
  logic [REMW-1:0] rem_q [3];
  logic [RW-1:0]   ring_q;
  logic [31:0]     drop_q, pub_q;

  for (genvar k = 0; k < 3; k++) begin : g_phase
    localparam longint INC   = longint'(MULT[k]) << (B + 1);
    localparam int     INC_Q = int'(INC / TWO_S);
    localparam int     INC_R = int'(INC % TWO_S);
    logic [REMW-1:0] rem_sum;
    logic            carry;
    assign rem_sum = rem_q[k] + REMW'(INC_R);
    assign carry   = rem_sum >= REMW'(TWO_S);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        idx_q[k] <= '0;
        rem_q[k] <= REMW'(STEPS_PER_REV);
      end else if (cmd_i.accept) begin
        idx_q[k] <= idx_q[k] + B'(INC_Q) + B'(carry);
        rem_q[k] <= carry ? rem_sum - REMW'(TWO_S) : rem_sum;
      end
    end
  end

  // Ring and point counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      drop_q <= '0;
      pub_q  <= '0;
    end else if (cmd_i.accept) begin
      ring_q <= (ring_q == RW'(RING_COUNT - 1)) ? '0 : ring_q + RW'(1);
      if (sink_full_i) drop_q <= drop_q + 32'd1;
      else             pub_q  <= pub_q + 32'd1;
    end
  end

  // Item registers captured on an input transfer.
  logic [63:0]  tick_q;
  logic         full_q;
  logic [3:0]   ring_item_q;
  logic [B-1:0] i1_q, i3_q, i7_q;
  logic [31:0]  drop_item_q, pub_item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tick_q      <= tick_time_ns_i;
      full_q      <= sink_full_i;
      ring_item_q <= 4'(ring_q);
      i1_q        <= idx_q[0];
      i3_q        <= idx_q[1];
      i7_q        <= idx_q[2];
      drop_item_q <= sink_full_i ? drop_q + 32'd1 : drop_q;
      pub_item_q  <= sink_full_i ? pub_q : pub_q + 32'd1;
    end
  end

  // Table lookups, range and intensity.
  logic signed [17:0] s3, s7;
  logic [16:0]        u3, u7;
  logic [21:0]        r_scaled;
  logic signed [17:0] sin_a_q, cos_a_q;
  logic [15:0]        r_q, bright_q;

  always_comb begin
    s3       = sine_at(i3_q, qtab);
    s7       = sine_at(i7_q, qtab);
    u3       = 17'(s3 + 18'sd32768);
    u7       = 17'(s7 + 18'sd32768);
    r_scaled = 22'(({5'b0, u3} << 4) + ({5'b0, u3} << 3) + {5'b0, u3} + 22'd32);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      sin_a_q  <= sine_at(i1_q, qtab);
      cos_a_q  <= sine_at(i1_q + B'(QN), qtab);
      r_q      <= 16'd5120 + 16'(r_scaled >> 6);
      bright_q <= 16'd16384 + 16'((18'(u7) + 18'd1) >> 1);
    end
  end

  // Shared multiplier with round half up by 2^15.
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod, rnd;
  logic signed [16:0] rh_q;
  logic signed [15:0] px_q, py_q, pz_q;

  always_comb begin
    case (cmd_i.mul_sel)
      slpg_pkg::MUL_RH: begin
        mul_a = $signed({2'b0, r_q});
        mul_b = 18'(slpg_pkg::ELEV_COS[ring_item_q]);
      end
      slpg_pkg::MUL_PZ: begin
        mul_a = $signed({2'b0, r_q});
        mul_b = 18'(slpg_pkg::ELEV_SIN[ring_item_q]);
      end
      slpg_pkg::MUL_PX: begin
        mul_a = 18'(rh_q);
        mul_b = cos_a_q;
      end
      default: begin
        mul_a = 18'(rh_q);
        mul_b = sin_a_q;
      end
    endcase
    prod = mul_a * mul_b;
    rnd  = (prod + 36'sd16384) >>> 15;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        slpg_pkg::MUL_RH: rh_q <= rnd[16:0];
        slpg_pkg::MUL_PZ: pz_q <= rnd[15:0];
        slpg_pkg::MUL_PX: px_q <= rnd[15:0];
        default:          py_q <= rnd[15:0];
      endcase
    end
  end

  // Output register decouples the sink from the sequencer.
  assign status_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_x_o           <= px_q;
      pos_y_o           <= py_q;
      pos_z_o           <= pz_q;
      brightness_o      <= bright_q;
      laser_ring_o      <= ring_item_q;
      stamp_ns_o        <= tick_q;
      accepted_o        <= !full_q;
      dropped_total_o   <= drop_item_q;
      published_total_o <= pub_item_q;
    end
  end

endmodule
`default_nettype wire
